// ===== hdl/srs_pkg.sv =====
// Shared types and constants for the striped read splitter.
// Holds the stripe geometry, operation and status codes, and the
// command descriptor passed from the sequencer to the output stage.
package srs_pkg;

	// Stripe geometry: 4096-byte sectors, 8 zones per node, 16-sector chunks
	localparam int SECTOR_BITS     = 12;
	localparam int ZONE_BITS       = 3;
	localparam int CHUNK_BITS      = 4;
	localparam int NODE_BITS       = 6;
	localparam int TABLE_AW        = NODE_BITS + ZONE_BITS;
	localparam int ADDR_W          = 48;
	// Stripe row of the offset plus one bit, since a run may step past the top row
	localparam int NLEVEL_W        = ADDR_W - SECTOR_BITS - ZONE_BITS - CHUNK_BITS + 1;
	localparam int ZONE_OFF_W      = NLEVEL_W + CHUNK_BITS;
	localparam int SEC_SIZE_W      = 33 - SECTOR_BITS;
	localparam int COUNT_W         = CHUNK_BITS + 1;
	localparam int SPAN_W          = SECTOR_BITS + CHUNK_BITS + 1;
	localparam int INDEX_W         = 6;
	localparam int SECTORS_PER_CMD = 16;
	localparam int MAX_COMMANDS    = 64;
	// A run may hold this many sectors beyond its first command
	localparam int MAX_REST        = (MAX_COMMANDS - 1) * SECTORS_PER_CMD;

	typedef enum logic {
		OP_READ = 1'b0,
		OP_LOAD = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_ZERO     = 2'd1,
		ST_TOO_MANY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		GEN_IDLE,
		GEN_SIZE,
		GEN_CHECK,
		GEN_RUN
	} gen_state_t;

	// Table read request from the sequencer
	typedef struct packed {
		logic                en;
		logic [TABLE_AW-1:0] addr;
	} mem_rd_t;

	// One command (or error result) before the zone base is added
	typedef struct packed {
		logic                   valid;
		logic                   last;
		status_t                status;
		logic [INDEX_W-1:0]     index;
		logic [ZONE_BITS-1:0]   zone;
		logic [ZONE_OFF_W-1:0]  zone_off;
		logic [COUNT_W-1:0]     count;
		logic [SECTOR_BITS-1:0] data_offset;
		logic [31:0]            buffer_offset;
		logic [SPAN_W-1:0]      copy_bytes;
	} cmd_desc_t;

endpackage

// ===== hdl/srs_base_mem.sv =====
// Zone base sector table: one write port, one read port, registered read.
// Depends on srs_pkg for the address and data widths.
// Contents are undefined until loaded.
module srs_base_mem import srs_pkg::*; (
	input  logic                clk,
	input  logic                wr_en,
	input  logic [TABLE_AW-1:0] wr_addr,
	input  logic [ADDR_W-1:0]   wr_data,
	input  logic                rd_en,
	input  logic [TABLE_AW-1:0] rd_addr,
	output logic [ADDR_W-1:0]   rd_data
);

	logic [ADDR_W-1:0] mem [2**TABLE_AW];

	// Write a loaded base
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read, updated only while rd_en is high
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hdl/srs_cmd_gen.sv =====
// Command sequencer: sizes a read, checks the command limit, then walks
// the stripe one chunk per cycle, issuing table reads and descriptors.
// Depends on srs_pkg.
module srs_cmd_gen import srs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start_read,
	input  logic [NODE_BITS-1:0] node,
	input  logic [ADDR_W-1:0]    byte_offset,
	input  logic [31:0]          byte_count,
	output logic        busy,
	output mem_rd_t     rd,
	output cmd_desc_t   desc
);

	gen_state_t state_q, state_d;

	logic [NODE_BITS-1:0]   node_q;
	logic [SECTOR_BITS-1:0] misalign_q;
	logic [CHUNK_BITS-1:0]  within_q;
	logic [ZONE_BITS-1:0]   zidx_q;
	logic [NLEVEL_W-1:0]    nlevel_q;
	logic [31:0]            left_q;
	logic                   zero_q;
	logic [SEC_SIZE_W-1:0]  secs_due_q;
	logic [COUNT_W-1:0]     read_num_q;
	logic [SPAN_W-1:0]      span_q;
	logic [31:0]            bytes_off_q;
	logic [INDEX_W-1:0]     idx_q;

	// Sizing and first-command terms
	logic [32:0]            size_sum;
	logic [COUNT_W-1:0]     first_max;
	logic [COUNT_W-1:0]     read_num0;
	logic [10:0]            rest_bound;
	logic                   too_many;

	// Per-command terms
	logic [32:0]            left_diff;
	logic [SPAN_W-1:0]      copy;
	logic                   run_last;
	logic [SEC_SIZE_W-1:0]  secs_due_n;
	logic [COUNT_W-1:0]     read_num_n;

	assign size_sum   = {1'b0, left_q} + 33'(misalign_q) + 33'((1 << SECTOR_BITS) - 1);
	assign first_max  = COUNT_W'(SECTORS_PER_CMD) - COUNT_W'(within_q);
	assign read_num0  = (secs_due_q < SEC_SIZE_W'(first_max)) ? secs_due_q[COUNT_W-1:0]
		: first_max;
	assign rest_bound = 11'(MAX_REST + SECTORS_PER_CMD) - 11'(within_q);
	assign too_many   = secs_due_q > SEC_SIZE_W'(rest_bound);

	// Clip copy to the bytes still wanted with one subtract
	assign left_diff  = {1'b0, left_q} - 33'(span_q);
	assign copy       = left_diff[32] ? left_q[SPAN_W-1:0] : span_q;
	assign run_last   = secs_due_q == SEC_SIZE_W'(read_num_q);
	assign secs_due_n = secs_due_q - SEC_SIZE_W'(read_num_q);
	assign read_num_n = (secs_due_n > SEC_SIZE_W'(SECTORS_PER_CMD)) ?
		COUNT_W'(SECTORS_PER_CMD) : secs_due_n[COUNT_W-1:0];

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= GEN_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, table read and descriptor
	always_comb begin
		state_d = state_q;
		rd      = '0;
		desc    = '0;
		busy    = 1'b1;
		unique case (state_q)
			GEN_IDLE: begin
				busy = 1'b0;
				if (start_read) begin
					state_d = GEN_SIZE;
				end
			end
			GEN_SIZE: begin
				state_d = GEN_CHECK;
			end
			GEN_CHECK: begin
				if (zero_q) begin
					desc.valid  = 1'b1;
					desc.last   = 1'b1;
					desc.status = ST_ZERO;
					state_d     = GEN_IDLE;
				end else if (too_many) begin
					desc.valid  = 1'b1;
					desc.last   = 1'b1;
					desc.status = ST_TOO_MANY;
					state_d     = GEN_IDLE;
				end else begin
					state_d = GEN_RUN;
				end
			end
			GEN_RUN: begin
				rd.en              = 1'b1;
				rd.addr            = {node_q, zidx_q};
				desc.valid         = 1'b1;
				desc.last          = run_last;
				desc.status        = ST_OK;
				desc.index         = idx_q;
				desc.zone          = zidx_q;
				desc.zone_off      = {nlevel_q, within_q};
				desc.count         = read_num_q;
				desc.data_offset   = misalign_q;
				desc.buffer_offset = bytes_off_q;
				desc.copy_bytes    = copy;
				if (run_last) begin
					state_d = GEN_IDLE;
				end
			end
			default: begin
				state_d = GEN_IDLE;
			end
		endcase
	end

	// Datapath registers: capture, size, first command, then advance per chunk
	always_ff @(posedge clk) begin
		case (state_q)
			GEN_IDLE: begin
				if (start_read) begin
					node_q     <= node;
					misalign_q <= byte_offset[SECTOR_BITS-1:0];
					within_q   <= byte_offset[SECTOR_BITS +: CHUNK_BITS];
					zidx_q     <= byte_offset[SECTOR_BITS + CHUNK_BITS +: ZONE_BITS];
					nlevel_q   <= NLEVEL_W'(byte_offset[ADDR_W-1 :
						SECTOR_BITS + CHUNK_BITS + ZONE_BITS]);
					left_q     <= byte_count;
					zero_q     <= byte_count == '0;
				end
			end
			GEN_SIZE: begin
				secs_due_q <= size_sum[32:SECTOR_BITS];
			end
			GEN_CHECK: begin
				read_num_q  <= read_num0;
				span_q      <= SPAN_W'({read_num0, {SECTOR_BITS{1'b0}}}) - SPAN_W'(misalign_q);
				bytes_off_q <= '0;
				idx_q       <= '0;
			end
			GEN_RUN: begin
				secs_due_q  <= secs_due_n;
				left_q      <= left_diff[32] ? '0 : left_diff[31:0];
				bytes_off_q <= bytes_off_q + 32'(copy);
				idx_q       <= idx_q + INDEX_W'(1);
				zidx_q      <= zidx_q + ZONE_BITS'(1);
				if (zidx_q == '1) begin
					nlevel_q <= nlevel_q + NLEVEL_W'(1);
				end
				within_q    <= '0;
				misalign_q  <= '0;
				read_num_q  <= read_num_n;
				span_q      <= SPAN_W'({read_num_n, {SECTOR_BITS{1'b0}}});
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== hdl/striped_read_splitter_core.sv =====
// Top level of the striped read splitter: base table, command sequencer
// and the output stage that adds the zone base. Depends on srs_pkg,
// srs_base_mem and srs_cmd_gen.
//
//  channel  | handshake               | fields
//  ---------+-------------------------+-------------------------------------------
//  item in  | start & !busy           | operation node zone_slot base_sector
//           |                         | byte_offset byte_count
//  result   | strobe (one cycle each) | command_index zone_index sector_address
//           |                         | sector_count data_offset buffer_offset
//           |                         | copy_bytes status last
//
// A load item is written to the table on accept; busy stays low after it.
// A read item holds busy through the sizing and limit-check states and then for
// one run state per command; an error result ends it after the limit check.
// Error results leave from the limit check and commands from the run state, each
// through the descriptor register that waits out the table read and then the
// output register with the add; commands follow one per cycle as the sequencer
// walks one chunk per cycle. Reset clears the sequencer and output strobes; the
// table is undefined until loaded. Results cannot be stalled.
module striped_read_splitter_core import srs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        operation,
	input  logic [5:0]  node,
	input  logic [2:0]  zone_slot,
	input  logic [47:0] base_sector,
	input  logic [47:0] byte_offset,
	input  logic [31:0] byte_count,
	output logic        strobe,
	output logic [5:0]  command_index,
	output logic [2:0]  zone_index,
	output logic [47:0] sector_address,
	output logic [4:0]  sector_count,
	output logic [11:0] data_offset,
	output logic [31:0] buffer_offset,
	output logic [16:0] copy_bytes,
	output logic [1:0]  status,
	output logic        last
);

	logic            accept;
	logic            load_wr;
	logic            start_read;
	mem_rd_t         rd;
	logic [ADDR_W-1:0] rd_data;
	cmd_desc_t       desc;
	cmd_desc_t       desc_s1;

	// Split accepted items into loads and reads
	assign accept     = start && !busy;
	assign load_wr    = accept && (op_t'(operation) == OP_LOAD);
	assign start_read = accept && (op_t'(operation) == OP_READ);

	srs_base_mem u_mem (
		.clk     (clk),
		.wr_en   (load_wr),
		.wr_addr ({node, zone_slot}),
		.wr_data (base_sector),
		.rd_en   (rd.en),
		.rd_addr (rd.addr),
		.rd_data (rd_data)
	);

	srs_cmd_gen u_gen (
		.clk         (clk),
		.arst_n      (arst_n),
		.start_read  (start_read),
		.node        (node),
		.byte_offset (byte_offset),
		.byte_count  (byte_count),
		.busy        (busy),
		.rd          (rd),
		.desc        (desc)
	);

	// Hold the descriptor while the table read completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			desc_s1 <= '0;
		end else begin
			desc_s1 <= desc;
		end
	end

	// Add the zone base and register the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= desc_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		command_index  <= desc_s1.index;
		zone_index     <= desc_s1.zone;
		sector_address <= (desc_s1.status == ST_OK) ?
			rd_data + ADDR_W'(desc_s1.zone_off) : '0;
		sector_count   <= desc_s1.count;
		data_offset    <= desc_s1.data_offset;
		buffer_offset  <= desc_s1.buffer_offset;
		copy_bytes     <= desc_s1.copy_bytes;
		status         <= desc_s1.status;
		last           <= desc_s1.last;
	end

	// A read item always raises busy for sizing
	assert property (@(posedge clk) disable iff (!arst_n)
		start_read |=> busy)
		else $error("busy not raised after read accept");

	// Error results stand alone at the head of a run
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (status != ST_OK) |-> last && (command_index == '0))
		else $error("error result is not a single last result");

	// Commands of a run leave back to back
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe && (command_index == $past(command_index) + 6'd1))
		else $error("gap or index skip inside a run");

	// Only the first command of a run carries a data offset
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (command_index != '0) |-> data_offset == '0)
		else $error("data offset on a later command");

	// A run ends before the next one can start
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |=> !strobe)
		else $error("result follows last without a new item");

endmodule
